// File: design/qrs_pkg.sv
// Package for the quadratic root solver: root count codes and result width.
// No dependencies.
package qrs_pkg;

    localparam int ROOT_WIDTH = 40;

    typedef enum logic [1:0] {
        CNT_NONE  = 2'd0,
        CNT_ONE   = 2'd1,
        CNT_TWO   = 2'd2,
        CNT_AZERO = 2'd3
    } t_root_count;

endpackage

// File: design/quadratic_root_solver.sv
// Quadratic root solver top level: discriminant, pipelined square root and two
// pipelined dividers. Depends on qrs_pkg.
//
// Usage:
//   Input channel  i_valid / o_stall carries the coefficients a, b and c.
//   Output channel o_valid / i_stall carries the root count and two roots
//   in signed fixed point with FRAC_BITS fraction bits.
//   A transfer happens on a rising edge where valid is high and stall is low.
//   One coefficient set enters per cycle while o_stall is low; every item
//   gives exactly one result. A result passes one register for the inputs,
//   one for the products, one for the discriminant, one square root stage
//   per root bit, one stage for the numerators, one restoring divide stage
//   per quotient bit and the output register.
//   Throughput is one item per cycle unless the receiver stalls. When the
//   receiver stalls a valid result, the whole pipeline holds and o_stall
//   rises; nothing is dropped or repeated.
//   Bubbles are not squeezed out while the output is held.
//   Reset (synchronous, active low) clears every stage valid bit; the block
//   can take an item as soon as reset is released.
//   A zero leading coefficient gives count 3 and zero roots.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [COEF_WIDTH-1:0]         i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]         i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]         i_coef_c,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [1:0]                           o_root_count,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0] o_first_root,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0] o_second_root
);
    import qrs_pkg::*;

    localparam int CW  = COEF_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int DW  = 2 * CW + 3;           // discriminant, signed
    localparam int SW  = CW + FB + 2;          // square root bits
    localparam int VW  = 2 * SW;               // radicand bits
    localparam int NBW = CW + FB + 1;          // -b scaled, signed
    localparam int NW  = CW + FB + 3;          // numerator magnitude
    localparam int NSW = NW + 1;               // numerator, signed
    localparam int XW  = (NW + 2 > ROOT_WIDTH + 1) ? NW + 2 : ROOT_WIDTH + 1;

    typedef struct packed {
        logic                  valid;
        t_root_count           cnt;
        logic                  a_neg;
        logic signed [NBW-1:0] nb;
        logic [CW:0]           den;
    } t_ctl;

    typedef struct packed {
        t_ctl          ctl;
        logic [SW+1:0] rem;
        logic [SW-1:0] root;
        logic [VW-1:0] v;
    } t_sq;

    typedef struct packed {
        logic          valid;
        t_root_count   cnt;
        logic [CW:0]   den;
        logic          neg1;
        logic          neg2;
        logic [CW+1:0] rem1;
        logic [CW+1:0] rem2;
        logic [NW-1:0] num1;
        logic [NW-1:0] num2;
    } t_dv;

    function automatic logic signed [ROOT_WIDTH-1:0] sat_root(
        input logic          neg,
        input logic [NW-1:0] mag
    );
        logic signed [XW-1:0] val;
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        val = XW'($signed({1'b0, mag}));
        if (neg) val = -val;
        hi = XW'($signed({1'b0, {(ROOT_WIDTH-1){1'b1}}}));
        lo = -hi - XW'(1);
        if (val > hi) val = hi;
        if (val < lo) val = lo;
        return val[ROOT_WIDTH-1:0];
    endfunction

    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Stage 0: input register
    logic                  r0_valid;
    logic signed [CW-1:0]  r0_a, r0_b, r0_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= i_valid;
            r0_a     <= i_coef_a;
            r0_b     <= i_coef_b;
            r0_c     <= i_coef_c;
        end
    end

    // Stage 1: products, scaled -b and denominator
    t_ctl                    r1_ctl;
    logic signed [2*CW-1:0]  r1_bsq, r1_ac;
    logic signed [NBW-1:0]   n1_nb;
    logic signed [CW:0]      n1_a2;

    always_comb begin
        n1_nb = -(NBW'(r0_b) <<< FB);
        n1_a2 = (CW+1)'(r0_a) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
        end else if (w_adv) begin
            r1_ctl.valid <= r0_valid;
            r1_ctl.cnt   <= (r0_a == '0) ? CNT_AZERO : CNT_TWO;
            r1_ctl.a_neg <= r0_a[CW-1];
            r1_ctl.nb    <= n1_nb;
            r1_ctl.den   <= n1_a2[CW] ? (CW+1)'(-n1_a2) : (CW+1)'(n1_a2);
            r1_bsq       <= (2*CW)'(r0_b * r0_b);
            r1_ac        <= (2*CW)'(r0_a * r0_c);
        end
    end

    // Stage 2: discriminant and root count, start of the square root
    logic signed [DW-1:0] n2_d;
    t_root_count          n2_cnt;
    logic [DW-1:0]        n2_dmag;

    always_comb begin
        n2_d    = DW'(r1_bsq) - (DW'(r1_ac) <<< 2);
        n2_dmag = n2_d[DW-1] ? '0 : DW'(n2_d);
        if (r1_ctl.cnt == CNT_AZERO) begin
            n2_cnt = CNT_AZERO;
        end else if (n2_d[DW-1]) begin
            n2_cnt = CNT_NONE;
        end else if (n2_d == '0) begin
            n2_cnt = CNT_ONE;
        end else begin
            n2_cnt = CNT_TWO;
        end
    end

    t_sq r_sq [SW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0].ctl.valid <= 1'b0;
        end else if (w_adv) begin
            r_sq[0].ctl.valid <= r1_ctl.valid;
            r_sq[0].ctl.cnt   <= n2_cnt;
            r_sq[0].ctl.a_neg <= r1_ctl.a_neg;
            r_sq[0].ctl.nb    <= r1_ctl.nb;
            r_sq[0].ctl.den   <= r1_ctl.den;
            r_sq[0].rem       <= '0;
            r_sq[0].root      <= '0;
            r_sq[0].v         <= VW'(n2_dmag) << (2 * FB);
        end
    end

    // Square root: one result bit per stage
    for (genvar i = 1; i <= SW; i++) begin : g_sqrt
        logic [SW+1:0] n_cand;
        logic [SW+1:0] n_trial;
        logic          n_ge;

        always_comb begin
            n_cand  = {r_sq[i-1].rem[SW-1:0], r_sq[i-1].v[VW-1 -: 2]};
            n_trial = {r_sq[i-1].root, 2'b01};
            n_ge    = (n_cand >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[i].ctl.valid <= 1'b0;
            end else if (w_adv) begin
                r_sq[i].ctl  <= r_sq[i-1].ctl;
                r_sq[i].rem  <= n_ge ? n_cand - n_trial : n_cand;
                r_sq[i].root <= {r_sq[i-1].root[SW-2:0], n_ge};
                r_sq[i].v    <= r_sq[i-1].v << 2;
            end
        end
    end

    // Numerators -b*2^F +/- s, split into sign and magnitude
    logic signed [NSW-1:0] n_n1, n_n2;

    always_comb begin
        n_n1 = NSW'(r_sq[SW].ctl.nb) + NSW'($signed({1'b0, r_sq[SW].root}));
        n_n2 = NSW'(r_sq[SW].ctl.nb) - NSW'($signed({1'b0, r_sq[SW].root}));
    end

    t_dv r_dv [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].valid <= 1'b0;
        end else if (w_adv) begin
            r_dv[0].valid <= r_sq[SW].ctl.valid;
            r_dv[0].cnt   <= r_sq[SW].ctl.cnt;
            r_dv[0].den   <= r_sq[SW].ctl.den;
            r_dv[0].neg1  <= n_n1[NSW-1] ^ r_sq[SW].ctl.a_neg;
            r_dv[0].neg2  <= n_n2[NSW-1] ^ r_sq[SW].ctl.a_neg;
            r_dv[0].rem1  <= '0;
            r_dv[0].rem2  <= '0;
            r_dv[0].num1  <= n_n1[NSW-1] ? NW'(-n_n1) : NW'(n_n1);
            r_dv[0].num2  <= n_n2[NSW-1] ? NW'(-n_n2) : NW'(n_n2);
        end
    end

    // Restoring division of both numerators: one quotient bit per stage
    for (genvar j = 1; j <= NW; j++) begin : g_div
        logic [CW+1:0] n_c1, n_c2;
        logic          n_ge1, n_ge2;

        always_comb begin
            n_c1  = {r_dv[j-1].rem1[CW:0], r_dv[j-1].num1[NW-1]};
            n_c2  = {r_dv[j-1].rem2[CW:0], r_dv[j-1].num2[NW-1]};
            n_ge1 = (n_c1 >= (CW+2)'(r_dv[j-1].den));
            n_ge2 = (n_c2 >= (CW+2)'(r_dv[j-1].den));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j].valid <= 1'b0;
            end else if (w_adv) begin
                r_dv[j].valid <= r_dv[j-1].valid;
                r_dv[j].cnt   <= r_dv[j-1].cnt;
                r_dv[j].den   <= r_dv[j-1].den;
                r_dv[j].neg1  <= r_dv[j-1].neg1;
                r_dv[j].neg2  <= r_dv[j-1].neg2;
                r_dv[j].rem1  <= n_ge1 ? n_c1 - (CW+2)'(r_dv[j-1].den) : n_c1;
                r_dv[j].rem2  <= n_ge2 ? n_c2 - (CW+2)'(r_dv[j-1].den) : n_c2;
                r_dv[j].num1  <= {r_dv[j-1].num1[NW-2:0], n_ge1};
                r_dv[j].num2  <= {r_dv[j-1].num2[NW-2:0], n_ge2};
            end
        end
    end

    // Output register: sign, saturate, zero unused roots
    logic                          r_out_valid;
    t_root_count                   r_out_cnt;
    logic signed [ROOT_WIDTH-1:0]  r_out_first, r_out_second;
    logic signed [ROOT_WIDTH-1:0]  n_first, n_second;

    always_comb begin
        n_first  = sat_root(r_dv[NW].neg1, r_dv[NW].num1);
        n_second = sat_root(r_dv[NW].neg2, r_dv[NW].num2);
        if (r_dv[NW].cnt == CNT_NONE || r_dv[NW].cnt == CNT_AZERO) n_first = '0;
        if (r_dv[NW].cnt != CNT_TWO) n_second = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid  <= r_dv[NW].valid;
            r_out_cnt    <= r_dv[NW].cnt;
            r_out_first  <= n_first;
            r_out_second <= n_second;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_root_count  = r_out_cnt;
    assign o_first_root  = r_out_first;
    assign o_second_root = r_out_second;

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == CNT_NONE || o_root_count == CNT_AZERO)
        |-> o_first_root == '0)
        else $error("first root not zero without roots");

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count != CNT_TWO |-> o_second_root == '0)
        else $error("second root not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// File: test/qrs_checker.sv
// Checker for the quadratic root solver: watches both channels, predicts roots
// from the coefficients and compares each result. Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_coef_a,
    input  logic signed [15:0] i_coef_b,
    input  logic signed [15:0] i_coef_c,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_root_count,
    input  logic signed [39:0] i_first_root,
    input  logic signed [39:0] i_second_root,
    output int                 o_errors,
    output int                 o_pending
);
    import qrs_pkg::*;

    typedef struct packed {
        t_root_count       cnt;
        logic signed [39:0] r1;
        logic signed [39:0] r2;
    } t_roots;

    t_roots roots_q[$];

    // Floor square root of a nonnegative value, bit by bit.
    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0] res;
        logic [63:0] t;
        res = '0;
        for (int k = 63; k >= 0; k--) begin
            t = res | (64'd1 << k);
            if ({64'd0, t} * {64'd0, t} <= v) res = t;
        end
        return res;
    endfunction

    function automatic logic signed [39:0] clamp40(logic signed [63:0] q);
        if (q > 64'sd549755813887) return 40'sh7F_FFFF_FFFF;
        if (q < -64'sd549755813888) return 40'sh80_0000_0000;
        return q[39:0];
    endfunction

    function automatic t_roots solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                           logic signed [15:0] c);
        t_roots r;
        logic signed [63:0] disc;
        logic signed [63:0] nb;
        logic signed [63:0] den;
        logic signed [63:0] s;
        r = '0;
        if (a == 0) begin
            r.cnt = CNT_AZERO;
            return r;
        end
        disc = 64'(b) * 64'(b) - 64'sd4 * 64'(a) * 64'(c);
        nb = -64'(b) * 64'sd65536;
        den = 64'sd2 * 64'(a);
        if (disc < 0) begin
            r.cnt = CNT_NONE;
        end else if (disc == 0) begin
            r.cnt = CNT_ONE;
            r.r1 = clamp40(nb / den);
        end else begin
            s = $signed(isqrt({64'd0, disc} << 32));
            r.cnt = CNT_TWO;
            r.r1 = clamp40((nb + s) / den);
            r.r2 = clamp40((nb - s) / den);
        end
        return r;
    endfunction

    assign o_pending = roots_q.size();

    always @(posedge i_clk) begin
        t_roots want;
        if (!i_rst_n) begin
            roots_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (roots_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result at %0t", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    want = roots_q.pop_front();
                    if (i_root_count !== want.cnt || i_first_root !== want.r1
                            || i_second_root !== want.r2) begin
                        if (o_errors < 10)
                            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                     want.cnt, want.r1, want.r2,
                                     i_root_count, i_first_root, i_second_root);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall)
                roots_q.push_back(solve_roots(i_coef_a, i_coef_b, i_coef_c));
        end
    end
endmodule

// File: test/tb_quadratic_root_solver.sv
// Testbench top for the quadratic root solver: clock, reset, coefficient
// stimulus and verdict. Depends on qrs_pkg, quadratic_root_solver, qrs_checker.
`timescale 1ns / 1ps
module tb_quadratic_root_solver;
    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic signed [15:0] coef_a = 0;
    logic signed [15:0] coef_b = 0;
    logic signed [15:0] coef_c = 0;
    logic o_stall, o_valid;
    logic [1:0] o_root_count;
    logic signed [39:0] o_first_root, o_second_root;
    int errors, pending;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    quadratic_root_solver uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_coef_a(coef_a), .i_coef_b(coef_b), .i_coef_c(coef_c),
        .o_valid(o_valid), .i_stall(i_stall), .o_root_count(o_root_count),
        .o_first_root(o_first_root), .o_second_root(o_second_root)
    );

    qrs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_coef_a(coef_a), .i_coef_b(coef_b), .i_coef_c(coef_c),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_root_count(o_root_count),
        .i_first_root(o_first_root), .i_second_root(o_second_root),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver stalls in runs, with calm stretches.
    initial begin
        int mode;
        forever begin
            @(negedge i_clk);
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40)) begin
                i_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
                @(negedge i_clk);
            end
        end
    end

    // Present one item and hold it until the transfer.
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        i_valid <= 1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    // Build a polynomial from a root pair, or use small or fully random values.
    task automatic random_item();
        int a, r1, r2;
        logic [15:0] ra, rb, rc;
        ra = 16'($urandom); rb = 16'($urandom); rc = 16'($urandom);
        case ($urandom_range(0, 5))
            0: begin
                a = $urandom_range(1, 20) * ($urandom_range(0, 1) ? 1 : -1);
                r1 = $signed($urandom_range(0, 60)) - 30;
                r2 = $urandom_range(0, 1) ? r1 : $signed($urandom_range(0, 60)) - 30;
                ra = 16'(a); rb = 16'(-a * (r1 + r2)); rc = 16'(a * r1 * r2);
            end
            1: begin ra = 16'($urandom_range(0, 7) - 3); end
            2: begin ra = 16'($urandom_range(0, 255) - 128);
                     rb = 16'($urandom_range(0, 255) - 128);
                     rc = 16'($urandom_range(0, 255) - 128); end
            default: ;
        endcase
        send_coefs(ra, rb, rc);
    endtask

    initial begin
        logic [15:0] ext[5];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        foreach (ext[k]) send_coefs(ext[k], ext[(k + 1) % 5], ext[(k + 3) % 5]);
        send_coefs(16'd1, -16'sd2, 16'd1);
        send_coefs(16'd1, 16'd0, -16'sd4);
        send_coefs(16'd1, 16'd0, 16'd4);
        send_coefs(16'd0, 16'd5, 16'd3);
        send_coefs(16'd2, 16'd3, -16'sd7);
        send_coefs(16'h7FFF, 16'h8000, 16'h8000);
        send_coefs(16'h8000, 16'h7FFF, 16'h7FFF);
        send_coefs(16'h0001, 16'h8000, 16'h8000);
        send_coefs(16'hFFFF, 16'h7FFF, 16'h7FFF);
        repeat (1850) begin
            random_item();
            idle_gap();
        end
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule

// File: files.f
design/qrs_pkg.sv
design/quadratic_root_solver.sv
test/qrs_checker.sv
test/tb_quadratic_root_solver.sv
